>>> rtl/vopi_pkg.sv
// Shared types, constants and the arctangent table of the pose integrator.
`default_nettype none
package vopi_pkg;

    // fixed field widths
    localparam int unsigned DIV_NUM_W = 26;
    localparam int unsigned DIV_DEN_W = 10;
    localparam int unsigned MUL_W     = 32;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned COR_XY_W  = 34;
    localparam int unsigned COR_Z_W   = 27;
    localparam int unsigned ATAN_LEN  = 24;

    // angles in Q8.16 degrees
    localparam logic signed [COR_Z_W-1:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [COR_Z_W-1:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [COR_Z_W-1:0] QUARTER_TURN = 27'sd5898240;

    // rotating CORDIC start value, Q1.30 gain compensated
    localparam logic signed [COR_XY_W-1:0] CORDIC_K = 34'sd652032874;

    // register indexes on the configuration port
    localparam logic [3:0] REG_METRES_PER_PIXEL   = 4'd0;
    localparam logic [3:0] REG_MIN_INLIERS        = 4'd1;
    localparam logic [3:0] REG_MIN_CONFIDENCE     = 4'd2;
    localparam logic [3:0] REG_FULL_SCORE_INLIERS = 4'd3;

    typedef enum logic {
        COR_VECTOR,
        COR_ROTATE
    } cor_mode_t;

    // command word to the serial multiplier
    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } mul_cmd_t;

    // rounded atan(2^-i) in Q8.16 degrees
    function automatic logic signed [COR_Z_W-1:0] atan_tab(input logic [4:0] i);
        logic signed [COR_Z_W-1:0] v;
        case (i)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/vopi_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vopi_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [vopi_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [vopi_pkg::DIV_DEN_W-1:0] den,
    output logic      [vopi_pkg::DIV_NUM_W-1:0] quot,
    output logic                               done
);
    localparam int unsigned NW = vopi_pkg::DIV_NUM_W;
    localparam int unsigned DW = vopi_pkg::DIV_DEN_W;

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [4:0]    step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          qbit;

    // shift one dividend bit into the partial remainder
    always_comb begin
        trial = {rem_reg, num_reg[NW-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= qbit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
                num_reg  <= {num_reg[NW-2:0], qbit};
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/vopi_mul.sv
// Serial shift-add multiply-accumulate, one multiplier bit per cycle.
`default_nettype none
module vopi_mul (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire vopi_pkg::mul_cmd_t                    cmd,
    input  wire logic signed [vopi_pkg::MUL_W-1:0]     op_a,
    input  wire logic signed [vopi_pkg::MUL_W-1:0]     op_b,
    output logic signed      [vopi_pkg::ACC_W-1:0]     acc,
    output logic                                       done
);
    localparam int unsigned MW = vopi_pkg::MUL_W;
    localparam int unsigned AW = vopi_pkg::ACC_W;

    logic [AW-1:0]        ma_reg;
    logic [MW-1:0]        mb_reg;
    logic                 neg_reg;
    logic [4:0]           step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [AW-1:0] acc_reg;
    logic [MW-1:0]        a_mag;
    logic [MW-1:0]        b_mag;

    // operand magnitudes; the product sign is applied per partial product
    always_comb begin
        a_mag = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
        b_mag = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                ma_reg   <= AW'(a_mag);
                mb_reg   <= b_mag;
                neg_reg  <= op_a[MW-1] ^ op_b[MW-1] ^ cmd.sub;
                step_reg <= '0;
                busy_reg <= 1'b1;
                if (cmd.clr) begin
                    acc_reg <= '0;
                end
            end else if (busy_reg) begin
                if (mb_reg[0]) begin
                    acc_reg <= neg_reg ? acc_reg - $signed(ma_reg)
                                       : acc_reg + $signed(ma_reg);
                end
                ma_reg   <= {ma_reg[AW-2:0], 1'b0};
                mb_reg   <= {1'b0, mb_reg[MW-1:1]};
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(MW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/vopi_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotating.
`default_nettype none
module vopi_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   start,
    input  wire vopi_pkg::cor_mode_t                    mode,
    input  wire logic signed [vopi_pkg::COR_XY_W-1:0]   x0,
    input  wire logic signed [vopi_pkg::COR_XY_W-1:0]   y0,
    input  wire logic signed [vopi_pkg::COR_Z_W-1:0]    z0,
    output logic signed      [vopi_pkg::COR_XY_W-1:0]   x,
    output logic signed      [vopi_pkg::COR_XY_W-1:0]   y,
    output logic signed      [vopi_pkg::COR_Z_W-1:0]    z,
    output logic                                        done
);
    localparam int unsigned XW   = vopi_pkg::COR_XY_W;
    localparam int unsigned ZW   = vopi_pkg::COR_Z_W;
    localparam int unsigned LOOP = (STEPS < vopi_pkg::ATAN_LEN) ? STEPS
                                                                 : vopi_pkg::ATAN_LEN;

    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    vopi_pkg::cor_mode_t  mode_reg;
    logic [4:0]           step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;
    logic                 cw;

    // shifted terms and direction of this micro-rotation
    always_comb begin
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        ang = vopi_pkg::atan_tab(step_reg);
        cw  = (mode_reg == vopi_pkg::COR_VECTOR) ? (y_reg > 0) : (z_reg < 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x0;
                y_reg    <= y0;
                z_reg    <= z0;
                mode_reg <= mode;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cw) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(LOOP - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/visual_odometry_pose_integrator.sv
// Top level of the planar pose integrator: sequencer, state and result register.
//
// Input channel s_*: one word per camera frame (similarity transform, counts,
// present flag). Result channel m_*: one word per input word with the updated
// pose, the frame deltas, confidence and the valid flag. Config channel cfg_*:
// register writes, taken at any time (always ready), meant for idle periods.
// One frame runs on a sequencer over three shared serial units: a restoring
// divider (26 steps), a shift-add multiplier (32 steps) and an iterative
// CORDIC (CORDIC_STEPS steps, at most 24). A rejected frame takes two
// divisions and two products; an integrated frame adds two CORDIC runs and
// six more products. One frame is in work at a time; s_ready is high only
// while no frame runs, so a new frame is taken only once the last is finished.
// A finished result sits in the output register until m_ready; the next frame
// may be accepted meanwhile, and its result waits until the register is free.
// Synchronous reset clears position and heading to zero, loads the register
// defaults and drops m_valid.
`default_nettype none
module visual_odometry_pose_integrator #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_rot_cos_term,
    input  wire logic signed [15:0] s_rot_sin_term,
    input  wire logic signed [19:0] s_shift_x_px,
    input  wire logic signed [19:0] s_shift_y_px,
    input  wire logic        [9:0]  s_inlier_count,
    input  wire logic        [9:0]  s_match_count,
    input  wire logic               s_transform_present,
    // result words
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed      [31:0] m_pos_x,
    output logic signed      [31:0] m_pos_y,
    output logic signed      [24:0] m_heading_deg,
    output logic signed      [31:0] m_delta_x,
    output logic signed      [31:0] m_delta_y,
    output logic signed      [24:0] m_delta_heading,
    output logic             [9:0]  m_inliers_out,
    output logic             [16:0] m_confidence,
    output logic                    m_frame_valid,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [3:0]  cfg_index,
    input  wire logic        [23:0] cfg_data
);
    localparam int unsigned XW = vopi_pkg::COR_XY_W;
    localparam int unsigned ZW = vopi_pkg::COR_Z_W;
    localparam int unsigned AW = vopi_pkg::ACC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_CNT,
        ST_DIV_RAT,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_COR_VEC,
        ST_MUL_TX,
        ST_MUL_TY,
        ST_COR_ROT,
        ST_MUL_CDX,
        ST_MUL_SDY,
        ST_MUL_SDX,
        ST_MUL_CDY,
        ST_FINISH
    } state_t;

    state_t st_reg;

    // configuration registers
    logic [23:0] mpp_reg;
    logic [9:0]  min_inl_reg;
    logic [16:0] min_conf_reg;
    logic [9:0]  full_reg;

    // latched input word
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic signed [19:0] tx_reg;
    logic signed [19:0] ty_reg;
    logic [9:0]         inl_reg;
    logic [9:0]         mat_reg;
    logic               pres_reg;

    // working values
    logic [16:0]        cnt_reg;
    logic [16:0]        conf_reg;
    logic               valid_reg;
    logic signed [24:0] dh_reg;
    logic signed [31:0] dx_reg;
    logic signed [31:0] dy_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;
    logic               fold_reg;

    // pose state
    logic signed [31:0] acc_x_reg;
    logic signed [31:0] acc_y_reg;
    logic signed [24:0] acc_h_reg;

    // unit command registers
    logic                          div_start_reg;
    logic [vopi_pkg::DIV_NUM_W-1:0] div_num_reg;
    logic [vopi_pkg::DIV_DEN_W-1:0] div_den_reg;
    vopi_pkg::mul_cmd_t            mul_cmd_reg;
    logic signed [31:0]            mul_a_reg;
    logic signed [31:0]            mul_b_reg;
    logic                          cor_start_reg;
    vopi_pkg::cor_mode_t           cor_mode_reg;
    logic signed [XW-1:0]          cor_x0_reg;
    logic signed [XW-1:0]          cor_y0_reg;
    logic signed [ZW-1:0]          cor_z0_reg;

    // result register
    logic               m_valid_reg;
    logic signed [31:0] m_pos_x_reg;
    logic signed [31:0] m_pos_y_reg;
    logic signed [24:0] m_heading_reg;
    logic signed [31:0] m_dx_reg;
    logic signed [31:0] m_dy_reg;
    logic signed [24:0] m_dh_reg;
    logic [9:0]         m_inl_reg;
    logic [16:0]        m_conf_reg;
    logic               m_fv_reg;

    // unit outputs
    logic [vopi_pkg::DIV_NUM_W-1:0] div_q;
    logic                           div_done;
    logic signed [AW-1:0]           mul_acc;
    logic                           mul_done;
    logic signed [XW-1:0]           cor_x;
    logic signed [XW-1:0]           cor_y;
    logic signed [ZW-1:0]           cor_z;
    logic                           cor_done;

    // derived values
    logic [26:0]          conf_sum;
    logic [16:0]          conf_now;
    logic [31:0]          mag2;
    logic                 valid_now;
    logic signed [ZW-1:0] dh_clamp;
    logic signed [AW-1:0] rnd16;
    logic signed [AW-1:0] rnd30;
    logic signed [34:0]   sum_x;
    logic signed [34:0]   sum_y;
    logic signed [31:0]   sat_x;
    logic signed [31:0]   sat_y;
    logic signed [ZW-1:0] h_sum;
    logic signed [ZW-1:0] h_wrap;
    logic signed [ZW-1:0] rot_z;
    logic                 rot_fold;
    logic signed [31:0]   c_now;
    logic signed [31:0]   s_now;
    logic signed [XW-1:0] a_sc;
    logic signed [XW-1:0] b_sc;
    logic                 out_free;

    vopi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .quot    (div_q),
        .done    (div_done)
    );

    vopi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .acc     (mul_acc),
        .done    (mul_done)
    );

    vopi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start_reg),
        .mode    (cor_mode_reg),
        .x0      (cor_x0_reg),
        .y0      (cor_y0_reg),
        .z0      (cor_z0_reg),
        .x       (cor_x),
        .y       (cor_y),
        .z       (cor_z),
        .done    (cor_done)
    );

    // confidence, validity, rounding/saturation of unit results, heading wrap and fold
    always_comb begin
        conf_sum  = 27'(cnt_reg) + 27'(div_q);
        conf_now  = (mat_reg == 10'd0) ? 17'd0
                  : (conf_sum[26:1] > 26'd65536) ? 17'd65536 : conf_sum[17:1];
        mag2      = mul_acc[31:0];
        valid_now = pres_reg && (inl_reg >= min_inl_reg) && (conf_reg >= min_conf_reg)
                 && (mag2 >= 32'h0400_0000) && (mag2 <= 32'h2400_0000);
        dh_clamp  = (cor_z > vopi_pkg::HALF_TURN) ? vopi_pkg::HALF_TURN
                  : (cor_z < -vopi_pkg::HALF_TURN) ? -vopi_pkg::HALF_TURN : cor_z;
        rnd16     = (mul_acc + 64'sd32768) >>> 16;
        rnd30     = (mul_acc + 64'sd536870912) >>> 30;
        sum_x     = 35'(acc_x_reg) + 35'(rnd30);
        sum_y     = 35'(acc_y_reg) + 35'(rnd30);
        sat_x     = (sum_x > 35'sd2147483647) ? 32'sh7fff_ffff
                  : (sum_x < -35'sd2147483648) ? 32'sh8000_0000 : sum_x[31:0];
        sat_y     = (sum_y > 35'sd2147483647) ? 32'sh7fff_ffff
                  : (sum_y < -35'sd2147483648) ? 32'sh8000_0000 : sum_y[31:0];
        h_sum     = ZW'(acc_h_reg) + ZW'(dh_reg);
        h_wrap    = (h_sum > vopi_pkg::HALF_TURN) ? h_sum - vopi_pkg::FULL_TURN
                  : (h_sum < -vopi_pkg::HALF_TURN) ? h_sum + vopi_pkg::FULL_TURN : h_sum;
        rot_z     = ZW'(acc_h_reg);
        rot_fold  = 1'b0;
        if (rot_z > vopi_pkg::QUARTER_TURN) begin
            rot_z    = rot_z - vopi_pkg::HALF_TURN;
            rot_fold = 1'b1;
        end else if (rot_z < -vopi_pkg::QUARTER_TURN) begin
            rot_z    = rot_z + vopi_pkg::HALF_TURN;
            rot_fold = 1'b1;
        end
        c_now     = fold_reg ? 32'(-cor_x) : cor_x[31:0];
        s_now     = fold_reg ? 32'(-cor_y) : cor_y[31:0];
        a_sc      = XW'(a_reg) <<< 8;
        b_sc      = XW'(b_reg) <<< 8;
        out_free  = !m_valid_reg || m_ready;
    end

    // sequencer, pose state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            mpp_reg       <= 24'd33554;
            min_inl_reg   <= 10'd25;
            min_conf_reg  <= 17'd22938;
            full_reg      <= 10'd50;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_h_reg     <= '0;
            div_start_reg <= 1'b0;
            mul_cmd_reg   <= '0;
            cor_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            mul_cmd_reg   <= '0;
            cor_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // register writes
            if (cfg_valid) begin
                case (cfg_index)
                    vopi_pkg::REG_METRES_PER_PIXEL:   mpp_reg      <= cfg_data;
                    vopi_pkg::REG_MIN_INLIERS:        min_inl_reg  <= cfg_data[9:0];
                    vopi_pkg::REG_MIN_CONFIDENCE:     min_conf_reg <= cfg_data[16:0];
                    vopi_pkg::REG_FULL_SCORE_INLIERS: full_reg     <= cfg_data[9:0];
                    default: ;
                endcase
            end

            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        a_reg         <= s_rot_cos_term;
                        b_reg         <= s_rot_sin_term;
                        tx_reg        <= s_shift_x_px;
                        ty_reg        <= s_shift_y_px;
                        inl_reg       <= s_inlier_count;
                        mat_reg       <= s_match_count;
                        pres_reg      <= s_transform_present;
                        div_num_reg   <= {s_inlier_count, 16'd0};
                        div_den_reg   <= full_reg;
                        div_start_reg <= 1'b1;
                        st_reg        <= ST_DIV_CNT;
                    end
                end
                ST_DIV_CNT: begin
                    if (div_done) begin
                        cnt_reg       <= ((full_reg == 10'd0) || (inl_reg >= full_reg))
                                         ? 17'd65536 : div_q[16:0];
                        div_den_reg   <= mat_reg;
                        div_start_reg <= 1'b1;
                        st_reg        <= ST_DIV_RAT;
                    end
                end
                ST_DIV_RAT: begin
                    if (div_done) begin
                        conf_reg        <= conf_now;
                        mul_a_reg       <= 32'(a_reg);
                        mul_b_reg       <= 32'(a_reg);
                        mul_cmd_reg     <= '{start: 1'b1, clr: 1'b1, sub: 1'b0};
                        st_reg          <= ST_MUL_AA;
                    end
                end
                ST_MUL_AA: begin
                    if (mul_done) begin
                        mul_a_reg   <= 32'(b_reg);
                        mul_b_reg   <= 32'(b_reg);
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b0, sub: 1'b0};
                        st_reg      <= ST_MUL_BB;
                    end
                end
                ST_MUL_BB: begin
                    if (mul_done) begin
                        valid_reg <= valid_now;
                        if (valid_now) begin
                            cor_mode_reg  <= vopi_pkg::COR_VECTOR;
                            cor_x0_reg    <= a_reg[15] ? -a_sc : a_sc;
                            cor_y0_reg    <= a_reg[15] ? -b_sc : b_sc;
                            cor_z0_reg    <= !a_reg[15] ? '0
                                           : b_reg[15] ? -vopi_pkg::HALF_TURN
                                                       : vopi_pkg::HALF_TURN;
                            cor_start_reg <= 1'b1;
                            st_reg        <= ST_COR_VEC;
                        end else begin
                            dh_reg <= '0;
                            dx_reg <= '0;
                            dy_reg <= '0;
                            st_reg <= ST_FINISH;
                        end
                    end
                end
                ST_COR_VEC: begin
                    if (cor_done) begin
                        dh_reg      <= dh_clamp[24:0];
                        mul_a_reg   <= 32'(tx_reg);
                        mul_b_reg   <= {8'd0, mpp_reg};
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b1, sub: 1'b0};
                        st_reg      <= ST_MUL_TX;
                    end
                end
                ST_MUL_TX: begin
                    if (mul_done) begin
                        dx_reg      <= rnd16[31:0];
                        mul_a_reg   <= 32'(ty_reg);
                        mul_b_reg   <= {8'd0, mpp_reg};
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b1, sub: 1'b0};
                        st_reg      <= ST_MUL_TY;
                    end
                end
                ST_MUL_TY: begin
                    if (mul_done) begin
                        dy_reg        <= rnd16[31:0];
                        fold_reg      <= rot_fold;
                        cor_mode_reg  <= vopi_pkg::COR_ROTATE;
                        cor_x0_reg    <= vopi_pkg::CORDIC_K;
                        cor_y0_reg    <= '0;
                        cor_z0_reg    <= rot_z;
                        cor_start_reg <= 1'b1;
                        st_reg        <= ST_COR_ROT;
                    end
                end
                ST_COR_ROT: begin
                    if (cor_done) begin
                        c_reg       <= c_now;
                        s_reg       <= s_now;
                        mul_a_reg   <= c_now;
                        mul_b_reg   <= dx_reg;
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b1, sub: 1'b0};
                        st_reg      <= ST_MUL_CDX;
                    end
                end
                ST_MUL_CDX: begin
                    if (mul_done) begin
                        mul_a_reg   <= s_reg;
                        mul_b_reg   <= dy_reg;
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b0, sub: 1'b1};
                        st_reg      <= ST_MUL_SDY;
                    end
                end
                ST_MUL_SDY: begin
                    if (mul_done) begin
                        acc_x_reg   <= sat_x;
                        mul_a_reg   <= s_reg;
                        mul_b_reg   <= dx_reg;
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b1, sub: 1'b0};
                        st_reg      <= ST_MUL_SDX;
                    end
                end
                ST_MUL_SDX: begin
                    if (mul_done) begin
                        mul_a_reg   <= c_reg;
                        mul_b_reg   <= dy_reg;
                        mul_cmd_reg <= '{start: 1'b1, clr: 1'b0, sub: 1'b0};
                        st_reg      <= ST_MUL_CDY;
                    end
                end
                ST_MUL_CDY: begin
                    if (mul_done) begin
                        acc_y_reg <= sat_y;
                        acc_h_reg <= h_wrap[24:0];
                        st_reg    <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hand the word over once the result register is free
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_pos_x_reg   <= acc_x_reg;
                        m_pos_y_reg   <= acc_y_reg;
                        m_heading_reg <= acc_h_reg;
                        m_dx_reg      <= dx_reg;
                        m_dy_reg      <= dy_reg;
                        m_dh_reg      <= dh_reg;
                        m_inl_reg     <= inl_reg;
                        m_conf_reg    <= conf_reg;
                        m_fv_reg      <= valid_reg;
                        st_reg        <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready         = (st_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_pos_x         = m_pos_x_reg;
    assign m_pos_y         = m_pos_y_reg;
    assign m_heading_deg   = m_heading_reg;
    assign m_delta_x       = m_dx_reg;
    assign m_delta_y       = m_dy_reg;
    assign m_delta_heading = m_dh_reg;
    assign m_inliers_out   = m_inl_reg;
    assign m_confidence    = m_conf_reg;
    assign m_frame_valid   = m_fv_reg;

endmodule
`default_nettype wire

>>> rtl/vopi_checker.sv
// Port-level checks of the pose integrator, bound to the top level.
`default_nettype none
module vopi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_pos_x,
    input wire logic [31:0] m_delta_x,
    input wire logic [31:0] m_delta_y,
    input wire logic [24:0] m_delta_heading,
    input wire logic [16:0] m_confidence,
    input wire logic        m_frame_valid
);
    // reset leaves the block ready with nothing to deliver
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not idle after reset");

    // one frame at a time: accepting a word drops ready
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while a frame is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pos_x)))
        else $error("stalled result word changed");

    // rejected frames carry zero deltas
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_valid) |->
            (m_delta_x == 32'd0 && m_delta_y == 32'd0 && m_delta_heading == 25'd0))
        else $error("rejected frame with non-zero delta");

    // confidence never exceeds one
    a_conf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_confidence <= 17'd65536))
        else $error("confidence above one");

endmodule

bind visual_odometry_pose_integrator vopi_checker u_vopi_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pos_x         (m_pos_x),
    .m_delta_x       (m_delta_x),
    .m_delta_y       (m_delta_y),
    .m_delta_heading (m_delta_heading),
    .m_confidence    (m_confidence),
    .m_frame_valid   (m_frame_valid)
);
`default_nettype wire

>>> test/visual_odometry_pose_integrator_tb.sv
// Self-checking testbench of the planar pose integrator, with its own predictor.
`default_nettype none
module visual_odometry_pose_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS        = 16;
    localparam longint HALF_DEG     = 64'sd11796480;
    localparam longint FULL_DEG     = 64'sd23592960;
    localparam longint QUARTER_DEG  = 64'sd5898240;
    localparam longint UNIT_GAIN    = 64'sd652032874;
    localparam longint CYCLE_LIMIT  = 6000000;
    localparam int     SETTLE       = 500;
    // index past the register list, writes to it are dropped
    localparam logic [3:0] SPARE_INDEX = 4'd7;

    // atan(2^-i) in Q8.16 degrees
    localparam longint ANGLE_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0};

    typedef struct {
        logic signed [15:0] cos_term;
        logic signed [15:0] sin_term;
        logic signed [19:0] shift_x;
        logic signed [19:0] shift_y;
        logic        [9:0]  inliers;
        logic        [9:0]  match_cnt;
        logic               present;
    } frame_t;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [24:0] heading;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        logic [24:0] delta_heading;
        logic [9:0]  inliers;
        logic [16:0] confidence;
        logic        frame_valid;
    } pose_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic signed [15:0] s_rot_cos_term = '0;
    logic signed [15:0] s_rot_sin_term = '0;
    logic signed [19:0] s_shift_x_px = '0;
    logic signed [19:0] s_shift_y_px = '0;
    logic        [9:0]  s_inlier_count = '0;
    logic        [9:0]  s_match_count = '0;
    logic               s_transform_present = 1'b0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire  signed [31:0] m_pos_x;
    wire  signed [31:0] m_pos_y;
    wire  signed [24:0] m_heading_deg;
    wire  signed [31:0] m_delta_x;
    wire  signed [31:0] m_delta_y;
    wire  signed [24:0] m_delta_heading;
    wire         [9:0]  m_inliers_out;
    wire         [16:0] m_confidence;
    wire                m_frame_valid;
    logic               cfg_valid = 1'b0;
    wire                cfg_ready;
    logic        [3:0]  cfg_index = '0;
    logic        [23:0] cfg_data = '0;

    visual_odometry_pose_integrator u_top (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_rot_cos_term, .s_rot_sin_term,
        .s_shift_x_px, .s_shift_y_px, .s_inlier_count, .s_match_count,
        .s_transform_present,
        .m_valid, .m_ready, .m_pos_x, .m_pos_y, .m_heading_deg,
        .m_delta_x, .m_delta_y, .m_delta_heading, .m_inliers_out,
        .m_confidence, .m_frame_valid,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    // predictor copy of registers and pose
    longint scale_mpp, floor_inliers, floor_conf, full_inliers;
    longint pose_x, pose_y, pose_heading;

    pose_t  pending_poses[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     frames_sent = 0, poses_seen = 0, integrated = 0;
    bit     idling = 1'b1;
    int     hold_cycles = 0;

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("visual_odometry_pose_integrator_tb: errors");
            $finish;
        end
    end

    // vectoring CORDIC: heading change of (a, b)
    function automatic longint turn_angle(input longint a, input longint b);
        longint x, y, z, t;
        x = a * 256;
        y = b * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_DEG : -HALF_DEG;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += ANGLE_STEP[i];
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= ANGLE_STEP[i];
            end
            x = t;
        end
        if (z > HALF_DEG) z = HALF_DEG;
        if (z < -HALF_DEG) z = -HALF_DEG;
        return z;
    endfunction

    // rotating CORDIC: cos and sin of the heading, Q1.30
    function automatic void heading_basis(input longint th, output longint c,
                                          output longint s);
        longint x, y, z, t;
        bit     flip;
        x = UNIT_GAIN;
        y = 0;
        z = th;
        flip = 1'b0;
        if (z > QUARTER_DEG) begin
            z -= HALF_DEG;
            flip = 1'b1;
        end else if (z < -QUARTER_DEG) begin
            z += HALF_DEG;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= ANGLE_STEP[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += ANGLE_STEP[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint round_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // expected pose word for one frame; advances the predicted pose
    function automatic pose_t integrate_frame(input frame_t f);
        longint a, b, tx, ty, inl, mat, cnt, ratio, conf, mag2;
        longint dx, dy, dh, c, s, h;
        bit     ok;
        pose_t  r;
        a = f.cos_term;
        b = f.sin_term;
        tx = f.shift_x;
        ty = f.shift_y;
        inl = f.inliers;
        mat = f.match_cnt;
        conf = 0;
        dx = 0;
        dy = 0;
        dh = 0;
        if (mat != 0) begin
            if (full_inliers == 0 || inl >= full_inliers) cnt = 65536;
            else cnt = (inl * 65536) / full_inliers;
            ratio = (inl * 65536) / mat;
            conf = (cnt + ratio) >> 1;
            if (conf > 65536) conf = 65536;
        end
        mag2 = a * a + b * b;
        ok = f.present && inl >= floor_inliers && conf >= floor_conf &&
             mag2 >= (64'sd1 << 26) && mag2 <= (64'sd9 << 26);
        if (ok) begin
            dh = turn_angle(a, b);
            dx = round_shift(tx * scale_mpp, 16);
            dy = round_shift(ty * scale_mpp, 16);
            heading_basis(pose_heading, c, s);
            pose_x = clip32(pose_x + round_shift(c * dx - s * dy, 30));
            pose_y = clip32(pose_y + round_shift(s * dx + c * dy, 30));
            h = pose_heading + dh;
            if (h > HALF_DEG) h -= FULL_DEG;
            else if (h < -HALF_DEG) h += FULL_DEG;
            pose_heading = h;
        end
        r.pos_x = pose_x[31:0];
        r.pos_y = pose_y[31:0];
        r.heading = pose_heading[24:0];
        r.delta_x = dx[31:0];
        r.delta_y = dy[31:0];
        r.delta_heading = dh[24:0];
        r.inliers = inl[9:0];
        r.confidence = conf[16:0];
        r.frame_valid = ok;
        return r;
    endfunction

    task automatic compare_field(input string nm, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pose word %0d: %s expected %h got %h",
                         poses_seen, nm, want, got);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        pose_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("pose word with nothing expected");
            end else begin
                want = pending_poses.pop_front();
                compare_field("pos_x", want.pos_x, m_pos_x);
                compare_field("pos_y", want.pos_y, m_pos_y);
                compare_field("heading_deg", 32'(want.heading),
                              32'($unsigned(m_heading_deg)));
                compare_field("delta_x", want.delta_x, m_delta_x);
                compare_field("delta_y", want.delta_y, m_delta_y);
                compare_field("delta_heading", 32'(want.delta_heading),
                              32'($unsigned(m_delta_heading)));
                compare_field("inliers_out", 32'(want.inliers), 32'(m_inliers_out));
                compare_field("confidence", 32'(want.confidence), 32'(m_confidence));
                compare_field("frame_valid", 32'(want.frame_valid), 32'(m_frame_valid));
                if (want.frame_valid) integrated++;
            end
            poses_seen++;
        end
    end

    // offer one frame word, predict at acceptance
    task automatic send_frame(input frame_t f);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rot_cos_term <= f.cos_term;
        s_rot_sin_term <= f.sin_term;
        s_shift_x_px <= f.shift_x;
        s_shift_y_px <= f.shift_y;
        s_inlier_count <= f.inliers;
        s_match_count <= f.match_cnt;
        s_transform_present <= f.present;
        do @(posedge aclk); while (!s_ready);
        pending_poses = {pending_poses, integrate_frame(f)};
        frames_sent++;
    endtask

    // sender pause until all pose words are back and the block is idle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_poses.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            vopi_pkg::REG_METRES_PER_PIXEL:   scale_mpp = val;
            vopi_pkg::REG_MIN_INLIERS:        floor_inliers = val[9:0];
            vopi_pkg::REG_MIN_CONFIDENCE:     floor_conf = val[16:0];
            vopi_pkg::REG_FULL_SCORE_INLIERS: full_inliers = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [23:0] mpp, input logic [23:0] min_inl,
                            input logic [23:0] min_conf, input logic [23:0] full);
        write_reg(vopi_pkg::REG_METRES_PER_PIXEL, mpp);
        write_reg(vopi_pkg::REG_MIN_INLIERS, min_inl);
        write_reg(vopi_pkg::REG_MIN_CONFIDENCE, min_conf);
        write_reg(vopi_pkg::REG_FULL_SCORE_INLIERS, full);
    endtask

    function automatic frame_t make_frame(input int a, input int b, input int tx,
                                          input int ty, input int inl, input int mat,
                                          input bit pres);
        frame_t f;
        f.cos_term = 16'(a);
        f.sin_term = 16'(b);
        f.shift_x = 20'(tx);
        f.shift_y = 20'(ty);
        f.inliers = 10'(inl);
        f.match_cnt = 10'(mat);
        f.present = pres;
        return f;
    endfunction

    // mostly plausible frames; the rest raw noise
    function automatic frame_t random_frame();
        frame_t f;
        int     a, b, inl, mat, span;
        longint m2;
        if ($urandom_range(0, 4) == 0) begin
            f.cos_term = 16'($urandom);
            f.sin_term = 16'($urandom);
            f.shift_x = 20'($urandom);
            f.shift_y = 20'($urandom);
            f.inliers = 10'($urandom);
            f.match_cnt = 10'($urandom);
            f.present = 1'($urandom);
            return f;
        end
        do begin
            a = $urandom_range(0, 49152) - 24576;
            b = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 49152) - 24576
                                            : $urandom_range(0, 4000) - 2000;
            m2 = longint'(a) * a + longint'(b) * b;
        end while (m2 < (64'sd1 << 26) || m2 > (64'sd9 << 26));
        span = ($urandom_range(0, 3) == 0) ? 524287 : 8192;
        inl = $urandom_range(0, 3) == 0 ? $urandom_range(0, 60) : $urandom_range(20, 800);
        mat = $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : $urandom_range(inl, 1023);
        return make_frame(a, b, $urandom_range(0, 2 * span) - span,
                          $urandom_range(0, 2 * span) - span, inl, mat,
                          $urandom_range(0, 15) != 0);
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_frame(random_frame());
    endtask

    // directed corners under the reset register values
    task automatic test_directed_corners();
        send_frame(make_frame(16384, 0, 256, 0, 100, 100, 1));
        send_frame(make_frame(16384, 4096, 0, -256, 40, 0, 1));
        send_frame(make_frame(16384, 4096, 1000, 1000, 300, 200, 1));
        send_frame(make_frame(16384, 4096, 1000, 1000, 300, 400, 0));
        send_frame(make_frame(8192, 0, 500, -500, 60, 60, 1));
        send_frame(make_frame(8191, 0, 500, -500, 60, 60, 1));
        send_frame(make_frame(24576, 0, -700, 700, 60, 60, 1));
        send_frame(make_frame(24577, 0, -700, 700, 60, 60, 1));
        send_frame(make_frame(-16384, 0, 300, 300, 60, 60, 1));
        send_frame(make_frame(-16384, -100, 300, 300, 60, 60, 1));
        send_frame(make_frame(-16384, 100, 300, 300, 60, 60, 1));
        send_frame(make_frame(0, 16384, 524287, -524288, 60, 60, 1));
        send_frame(make_frame(0, -16384, -524288, 524287, 60, 60, 1));
        send_frame(make_frame(-32768, 32767, 0, 0, 1023, 1023, 1));
        send_frame(make_frame(32767, -32768, 0, 0, 1023, 1023, 1));
        send_frame(make_frame(16384, 0, 100, 100, 24, 24, 1));
        send_frame(make_frame(16384, 0, 100, 100, 25, 1023, 1));
        send_frame(make_frame(16384, 0, 100, 100, 0, 1, 1));
        drain();
    endtask

    // register extremes: zero full score, threshold of one, saturation
    task automatic test_register_extremes();
        set_regs(24'd1000, 24'd0, 24'd0, 24'd1024);
        write_reg(SPARE_INDEX, 24'hFFFFFF);
        send_frame(make_frame(16384, 0, 400, 400, 0, 5, 1));
        send_frame(make_frame(16384, 2000, -400, 400, 3, 900, 1));
        send_random(40);
        drain();
        set_regs(24'd16777215, 24'd1023, 24'd65536, 24'd1);
        send_frame(make_frame(16384, 0, 400, 400, 1023, 1023, 1));
        send_random(20);
        drain();
        set_regs(24'd16777215, 24'd0, 24'd0, 24'd1);
        repeat (20) send_frame(make_frame(16384, 0, 524287, 524287, 500, 500, 1));
        repeat (20) send_frame(make_frame(16384, 0, -524288, -524288, 500, 500, 1));
        drain();
    endtask

    // random phases across register settings
    task automatic test_random_phases();
        set_regs(24'd33554, 24'd25, 24'd22938, 24'd50);
        send_random(500);
        drain();
        set_regs(24'd0, 24'd0, 24'd0, 24'd1023);
        send_random(150);
        drain();
        set_regs(24'($urandom), 24'($urandom_range(0, 60)), 24'($urandom_range(0, 40000)),
                 24'($urandom_range(1, 1023)));
        send_random(300);
        drain();
        set_regs(24'($urandom_range(1000, 200000)), 24'd10, 24'd10000, 24'd0);
        send_random(300);
        drain();
    endtask

    // receiver holds off long while frames keep coming
    task automatic test_backpressure();
        idling = 1'b0;
        hold_cycles = 3000;
        send_random(12);
        drain();
        idling = 1'b1;
    endtask

    // closing stretch without any idling
    task automatic test_steady_stream();
        idling = 1'b0;
        set_regs(24'd65536, 24'd25, 24'd22938, 24'd50);
        send_random(300);
        drain();
    endtask

    initial begin
        scale_mpp = 33554;
        floor_inliers = 25;
        floor_conf = 22938;
        full_inliers = 50;
        pose_x = 0;
        pose_y = 0;
        pose_heading = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_steady_stream();
        if (pending_poses.size() != 0) mismatches++;
        $display("%0d frames sent, %0d pose words checked, %0d integrated, %0d mismatches",
                 frames_sent, poses_seen, integrated, mismatches);
        $display("register extremes, back-pressure and idle-free streaming covered");
        if (mismatches == 0) begin
            $display("visual_odometry_pose_integrator_tb: clean");
        end else begin
            $display("visual_odometry_pose_integrator_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> visual_odometry_pose_integrator.f
rtl/vopi_pkg.sv
rtl/vopi_div.sv
rtl/vopi_mul.sv
rtl/vopi_cordic.sv
rtl/visual_odometry_pose_integrator.sv
rtl/vopi_checker.sv
test/visual_odometry_pose_integrator_tb.sv
